// ----- hw/rtl/bab_pkg.sv -----
package bab_pkg;

    localparam int COORD_BITS_DEF          = 16;
    localparam int ANGLE_FRACTION_BITS_DEF = 16;
    localparam int CORDIC_STEPS_DEF        = 18;

    localparam int VEC_SCALE   = 24;
    localparam int VEC_GUARD   = 3;
    localparam int ANG_Q       = 30;
    localparam int OUT_W       = 20;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;
    localparam int TABLE_LEN   = 28;
    localparam int TAB_IDX_W   = 5;
    localparam int Z_W         = 32;
    localparam int ANG_W       = ANG_Q + OUT_W;

    localparam logic signed [ANG_W-1:0] HALF_PI_Q30       = 50'sd1686629713;
    localparam logic signed [ANG_W-1:0] PI_Q30            = 50'sd3373259426;
    localparam logic signed [ANG_W-1:0] THREE_HALF_PI_Q30 = 50'sd5059889139;

    typedef struct packed {
        logic valid;
        logic dx_zero;
        logic dy_neg;
        logic dx_pos;
    } bab_ctl_t;

    // atan(2^-i), radians * 2^30, rounded to nearest
    function automatic logic signed [Z_W-1:0] atan_q30(input logic [TAB_IDX_W-1:0] idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            5'd0:    v = 32'sd843314857;
            5'd1:    v = 32'sd497837829;
            5'd2:    v = 32'sd263043837;
            5'd3:    v = 32'sd133525159;
            5'd4:    v = 32'sd67021687;
            5'd5:    v = 32'sd33543516;
            5'd6:    v = 32'sd16775851;
            5'd7:    v = 32'sd8388437;
            5'd8:    v = 32'sd4194283;
            5'd9:    v = 32'sd2097149;
            5'd10:   v = 32'sd1048576;
            5'd11:   v = 32'sd524288;
            5'd12:   v = 32'sd262144;
            5'd13:   v = 32'sd131072;
            5'd14:   v = 32'sd65536;
            5'd15:   v = 32'sd32768;
            5'd16:   v = 32'sd16384;
            5'd17:   v = 32'sd8192;
            5'd18:   v = 32'sd4096;
            5'd19:   v = 32'sd2048;
            5'd20:   v = 32'sd1024;
            5'd21:   v = 32'sd512;
            5'd22:   v = 32'sd256;
            5'd23:   v = 32'sd128;
            5'd24:   v = 32'sd64;
            5'd25:   v = 32'sd32;
            5'd26:   v = 32'sd16;
            5'd27:   v = 32'sd8;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ----- hw/rtl/bab_prep.sv -----
module bab_prep #(
    parameter int COORD_BITS = bab_pkg::COORD_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     en,
    input  logic                     beat_in,
    input  logic signed [COORD_BITS-1:0] first_x,
    input  logic signed [COORD_BITS-1:0] first_y,
    input  logic signed [COORD_BITS-1:0] second_x,
    input  logic signed [COORD_BITS-1:0] second_y,
    output bab_pkg::bab_ctl_t        ctl_out,
    output logic signed [COORD_BITS+bab_pkg::VEC_SCALE+bab_pkg::VEC_GUARD:0] x_out,
    output logic signed [COORD_BITS+bab_pkg::VEC_SCALE+bab_pkg::VEC_GUARD:0] y_out
);
    import bab_pkg::*;

    localparam int D_W   = COORD_BITS + 1;
    localparam int VEC_W = COORD_BITS + VEC_SCALE + VEC_GUARD + 1;

    logic signed [D_W-1:0]   dx, dy, vx, vy;
    bab_ctl_t                ctl_reg, ctl_next;
    logic signed [VEC_W-1:0] x_reg, x_next, y_reg, y_next;

    always_comb begin
        dx = D_W'(first_x) - D_W'(second_x);
        dy = D_W'(second_y) - D_W'(first_y);
        vx = dx[D_W-1] ? -dx : dx;
        vy = dx[D_W-1] ? -dy : dy;
        ctl_next.valid   = beat_in;
        ctl_next.dx_zero = (dx == '0);
        ctl_next.dy_neg  = dy[D_W-1];
        ctl_next.dx_pos  = (dx != '0) && !dx[D_W-1];
        x_next = VEC_W'(vx) <<< VEC_SCALE;
        y_next = VEC_W'(vy) <<< VEC_SCALE;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg.valid <= 1'b0;
        end else if (en) begin
            ctl_reg.valid <= ctl_next.valid;
        end
        if (en) begin
            ctl_reg.dx_zero <= ctl_next.dx_zero;
            ctl_reg.dy_neg  <= ctl_next.dy_neg;
            ctl_reg.dx_pos  <= ctl_next.dx_pos;
            x_reg           <= x_next;
            y_reg           <= y_next;
        end
    end

    assign ctl_out = ctl_reg;
    assign x_out   = x_reg;
    assign y_out   = y_reg;

endmodule

// ----- hw/rtl/bab_cell.sv -----
module bab_cell #(
    parameter int COORD_BITS = bab_pkg::COORD_BITS_DEF,
    parameter int STEP       = 0
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     en,
    input  bab_pkg::bab_ctl_t        ctl_in,
    input  logic signed [COORD_BITS+bab_pkg::VEC_SCALE+bab_pkg::VEC_GUARD:0] x_in,
    input  logic signed [COORD_BITS+bab_pkg::VEC_SCALE+bab_pkg::VEC_GUARD:0] y_in,
    input  logic signed [bab_pkg::Z_W-1:0] z_in,
    output bab_pkg::bab_ctl_t        ctl_out,
    output logic signed [COORD_BITS+bab_pkg::VEC_SCALE+bab_pkg::VEC_GUARD:0] x_out,
    output logic signed [COORD_BITS+bab_pkg::VEC_SCALE+bab_pkg::VEC_GUARD:0] y_out,
    output logic signed [bab_pkg::Z_W-1:0] z_out
);
    import bab_pkg::*;

    localparam int VEC_W = COORD_BITS + VEC_SCALE + VEC_GUARD + 1;
    localparam logic signed [Z_W-1:0] ATAN_STEP = atan_q30(TAB_IDX_W'(STEP));

    logic signed [VEC_W-1:0] xs, ys;
    bab_ctl_t                ctl_reg;
    logic signed [VEC_W-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [Z_W-1:0]   z_reg, z_next;

    // floor shift; rotate toward the x axis
    always_comb begin
        xs = x_in >>> STEP;
        ys = y_in >>> STEP;
        if (y_in > 0) begin
            x_next = x_in + ys;
            y_next = y_in - xs;
            z_next = z_in + ATAN_STEP;
        end else begin
            x_next = x_in - ys;
            y_next = y_in + xs;
            z_next = z_in - ATAN_STEP;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg.valid <= 1'b0;
        end else if (en) begin
            ctl_reg.valid <= ctl_in.valid;
        end
        if (en) begin
            ctl_reg.dx_zero <= ctl_in.dx_zero;
            ctl_reg.dy_neg  <= ctl_in.dy_neg;
            ctl_reg.dx_pos  <= ctl_in.dx_pos;
            x_reg           <= x_next;
            y_reg           <= y_next;
            z_reg           <= z_next;
        end
    end

    assign ctl_out = ctl_reg;
    assign x_out   = x_reg;
    assign y_out   = y_reg;
    assign z_out   = z_reg;

endmodule

// ----- hw/rtl/bab_post.sv -----
module bab_post #(
    parameter int ANGLE_FRACTION_BITS = bab_pkg::ANGLE_FRACTION_BITS_DEF
) (
    input  bab_pkg::bab_ctl_t              ctl_in,
    input  logic signed [bab_pkg::Z_W-1:0] z_in,
    output logic [bab_pkg::OUT_W-1:0]      angle
);
    import bab_pkg::*;

    localparam int SHIFT = ANG_Q - ANGLE_FRACTION_BITS;
    localparam logic signed [ANG_W-1:0] HALF_LSB = ANG_W'(1) <<< (SHIFT - 1);

    logic signed [ANG_W-1:0] base, offs, sum;

    // rounding half added alongside the quadrant offset
    always_comb begin
        if (ctl_in.dx_zero) begin
            base = '0;
            offs = ctl_in.dy_neg ? HALF_PI_Q30 : THREE_HALF_PI_Q30;
        end else begin
            base = ANG_W'(z_in);
            offs = ctl_in.dx_pos ? PI_Q30 : '0;
        end
        sum   = base + offs + HALF_LSB;
        angle = sum[SHIFT +: OUT_W];
    end

endmodule

// ----- hw/rtl/bearing_angle_between_points.sv -----
// Bearing from point two to point one as atan(dy/dx) in radians, scaled by
// 2^ANGLE_FRACTION_BITS, with dx = first_x - second_x and dy = second_y - first_y;
// pi is added when dx is positive, and a vertical pair gives pi/2 (dy negative)
// or 3*pi/2. One beat is taken every clock while s_tready is high; a result passes
// through one difference stage, one CORDIC cell per iteration and
// one output register. A skid register behind the output keeps s_tready high
// while a single result waits on m_tready.
module bearing_angle_between_points #(
    parameter int COORD_BITS          = bab_pkg::COORD_BITS_DEF,
    parameter int ANGLE_FRACTION_BITS = bab_pkg::ANGLE_FRACTION_BITS_DEF,
    parameter int CORDIC_STEPS        = bab_pkg::CORDIC_STEPS_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    // first_x, first_y, second_x, second_y, zero pad
    input  logic [((4*COORD_BITS+7)/8)*8-1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // bearing_radians_q16, zero pad
    output logic [bab_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import bab_pkg::*;

    localparam int NSTEPS = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
    localparam int VEC_W  = COORD_BITS + VEC_SCALE + VEC_GUARD + 1;

    logic                    en;
    bab_ctl_t                ctl  [0:NSTEPS];
    logic signed [VEC_W-1:0] vx   [0:NSTEPS];
    logic signed [VEC_W-1:0] vy   [0:NSTEPS];
    logic signed [Z_W-1:0]   vz   [0:NSTEPS];
    logic [OUT_W-1:0]        angle;
    logic                    out_take;

    logic             out_valid_reg, out_valid_next;
    logic [OUT_W-1:0] out_data_reg, out_data_next;
    logic             skid_valid_reg, skid_valid_next;
    logic [OUT_W-1:0] skid_data_reg, skid_data_next;

    assign en       = !skid_valid_reg;
    assign s_tready = en;
    assign vz[0]    = '0;

    bab_prep #(
        .COORD_BITS(COORD_BITS)
    ) u_prep (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .beat_in (s_tvalid),
        .first_x (s_tdata[0*COORD_BITS +: COORD_BITS]),
        .first_y (s_tdata[1*COORD_BITS +: COORD_BITS]),
        .second_x(s_tdata[2*COORD_BITS +: COORD_BITS]),
        .second_y(s_tdata[3*COORD_BITS +: COORD_BITS]),
        .ctl_out (ctl[0]),
        .x_out   (vx[0]),
        .y_out   (vy[0])
    );

    for (genvar i = 0; i < NSTEPS; i++) begin : g_cell
        bab_cell #(
            .COORD_BITS(COORD_BITS),
            .STEP      (i)
        ) u_cell (
            .aclk   (aclk),
            .aresetn(aresetn),
            .en     (en),
            .ctl_in (ctl[i]),
            .x_in   (vx[i]),
            .y_in   (vy[i]),
            .z_in   (vz[i]),
            .ctl_out(ctl[i+1]),
            .x_out  (vx[i+1]),
            .y_out  (vy[i+1]),
            .z_out  (vz[i+1])
        );
    end

    bab_post #(
        .ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS)
    ) u_post (
        .ctl_in(ctl[NSTEPS]),
        .z_in  (vz[NSTEPS]),
        .angle (angle)
    );

    assign out_take = out_valid_reg && m_tready;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg) begin
            if (out_take) begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end else if (ctl[NSTEPS].valid) begin
            if (!out_valid_reg || out_take) begin
                out_data_next  = angle;
                out_valid_next = 1'b1;
            end else begin
                skid_data_next  = angle;
                skid_valid_next = 1'b1;
            end
        end else if (out_take) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - OUT_W){1'b0}}, out_data_reg};

endmodule

// ----- tb/bearing_angle_between_points_test.sv -----
`timescale 1ns / 100ps

module bearing_angle_between_points_test;

    localparam int STEPS     = bab_pkg::CORDIC_STEPS_DEF;
    localparam int FRAC      = bab_pkg::ANGLE_FRACTION_BITS_DEF;
    localparam int ANGLE_Q   = 30;
    localparam int VEC_SHIFT = 24;
    localparam int LATENCY   = STEPS + 2;
    localparam int N_RANDOM  = 1600;
    localparam int N_ROWS    = 23;

    localparam longint HALF_PI_Q30       = 64'sd1686629713;
    localparam longint PI_Q30            = 64'sd3373259426;
    localparam longint THREE_HALF_PI_Q30 = 64'sd5059889139;

    // atan(2^-i) in radians * 2^30
    localparam longint ATAN_Q30 [28] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
        16, 8
    };

    // vertical pair: pi/2 when dy < 0, else 3*pi/2
    localparam logic [19:0] VERT_DOWN_Q16 = 20'd102944;
    localparam logic [19:0] VERT_UP_Q16   = 20'd308831;

    typedef struct packed {
        logic signed [15:0] y2;
        logic signed [15:0] x2;
        logic signed [15:0] y1;
        logic signed [15:0] x1;
    } pair_t;

    typedef struct packed {
        pair_t       pts;
        logic        pinned;
        logic [19:0] want;
    } pair_row_t;

    // {y2, x2, y1, x1}, pinned, expected bearing
    localparam pair_row_t DIRECTED_ROWS [N_ROWS] = '{
        '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, VERT_UP_Q16},
        '{'{-16'sd5, 16'sd0, 16'sd5, 16'sd0}, 1'b1, VERT_DOWN_Q16},
        '{'{16'sd32767, 16'sd0, -16'sd32768, 16'sd0}, 1'b1, VERT_UP_Q16},
        '{'{-16'sd32768, 16'sd0, 16'sd32767, 16'sd0}, 1'b1, VERT_DOWN_Q16},
        '{'{-16'sd100, -16'sd32768, 16'sd100, -16'sd32768}, 1'b1, VERT_DOWN_Q16},
        '{'{16'sd0, 16'sd0, 16'sd0, 16'sd10}, 1'b0, 20'd0},
        '{'{16'sd0, 16'sd10, 16'sd0, 16'sd0}, 1'b0, 20'd0},
        '{'{16'sd7, -16'sd32768, 16'sd7, 16'sd32767}, 1'b0, 20'd0},
        '{'{16'sd7, 16'sd32767, 16'sd7, -16'sd32768}, 1'b0, 20'd0},
        '{'{16'sd32767, 16'sd0, -16'sd32768, 16'sd1}, 1'b0, 20'd0},
        '{'{-16'sd32768, 16'sd0, 16'sd32767, 16'sd1}, 1'b0, 20'd0},
        '{'{16'sd32767, 16'sd1, -16'sd32768, 16'sd0}, 1'b0, 20'd0},
        '{'{-16'sd32768, 16'sd1, 16'sd32767, 16'sd0}, 1'b0, 20'd0},
        '{'{16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767}, 1'b0, 20'd0},
        '{'{-16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768}, 1'b0, 20'd0},
        '{'{-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767}, 1'b0, 20'd0},
        '{'{16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768}, 1'b0, 20'd0},
        '{'{16'sd1, 16'sd0, 16'sd0, 16'sd1}, 1'b0, 20'd0},
        '{'{16'sd1, 16'sd1, 16'sd0, 16'sd0}, 1'b0, 20'd0},
        '{'{-16'sd1, 16'sd0, 16'sd0, 16'sd1}, 1'b0, 20'd0},
        '{'{-16'sd1, 16'sd1, 16'sd0, 16'sd0}, 1'b0, 20'd0},
        '{'{-16'sd1, -16'sd1, -16'sd1, -16'sd1}, 1'b1, VERT_UP_Q16},
        '{'{16'sd4000, -16'sd3000, -16'sd2222, 16'sd12345}, 1'b0, 20'd0}
    };

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [bab_pkg::OUT_TDATA_W-1:0] m_tdata;

    logic        pin_en  = 1'b0;
    logic [19:0] pin_val = '0;

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int fail_count     = 0;

    logic [19:0] bearing_q [$];

    bearing_angle_between_points #(
        .COORD_BITS          (16),
        .ANGLE_FRACTION_BITS (FRAC),
        .CORDIC_STEPS        (STEPS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [19:0] predict_bearing(pair_t p);
        longint dx;
        longint dy;
        longint vx;
        longint vy;
        longint xs;
        longint ys;
        longint ang;
        dx = longint'(p.x1) - longint'(p.x2);
        dy = longint'(p.y2) - longint'(p.y1);
        if (dx == 0) begin
            ang = (dy < 0) ? HALF_PI_Q30 : THREE_HALF_PI_Q30;
        end else begin
            vx  = ((dx < 0) ? -dx : dx) <<< VEC_SHIFT;
            vy  = ((dx < 0) ? -dy : dy) <<< VEC_SHIFT;
            ang = 0;
            for (int i = 0; i < STEPS && i < 28; i++) begin
                xs = vx >>> i;
                ys = vy >>> i;
                if (vy > 0) begin
                    vx  = vx + ys;
                    vy  = vy - xs;
                    ang = ang + ATAN_Q30[i];
                end else begin
                    vx  = vx - ys;
                    vy  = vy + xs;
                    ang = ang - ATAN_Q30[i];
                end
            end
            if (dx > 0) begin
                ang = ang + PI_Q30;
            end
        end
        ang = (ang + (64'sd1 <<< (ANGLE_Q - FRAC - 1))) >>> (ANGLE_Q - FRAC);
        return ang[19:0];
    endfunction

    function automatic logic signed [15:0] corner_coord();
        case ($urandom_range(4))
            0:       return -16'sd32768;
            1:       return -16'sd1;
            2:       return 16'sd0;
            3:       return 16'sd1;
            default: return 16'sd32767;
        endcase
    endfunction

    function automatic pair_t random_pair();
        pair_t p;
        int    pick;
        p    = pair_t'({$urandom, $urandom});
        pick = $urandom_range(99);
        if (pick < 15) begin
            p.x2 = p.x1;
        end else if (pick < 25) begin
            p.y2 = p.y1;
        end else if (pick < 40) begin
            p.x2 = p.x1 + 16'($urandom_range(16)) - 16'sd8;
            p.y2 = p.y1 + 16'($urandom_range(16)) - 16'sd8;
        end else if (pick < 50) begin
            p.x1 = corner_coord();
            p.y1 = corner_coord();
            p.x2 = corner_coord();
            p.y2 = corner_coord();
        end
        return p;
    endfunction

    // entered and left just after a falling edge
    task automatic send_pair(pair_t p, logic pinned, logic [19:0] want);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= p;
        pin_en   <= pinned;
        pin_val  <= want;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (bearing_q.size() != 0) @(negedge aclk);
    endtask

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge aclk) begin
        logic [19:0] want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                bearing_q.push_back(pin_en ? pin_val : predict_bearing(pair_t'(s_tdata)));
            end
            if (m_tvalid && m_tready) begin
                if (bearing_q.size() == 0) begin
                    $error("unexpected result beat: bearing_radians_q16 = %0d",
                           $signed(m_tdata[19:0]));
                    fail_count++;
                end else begin
                    want = bearing_q.pop_front();
                    if (m_tdata[19:0] !== want) begin
                        $error("bearing_radians_q16: expected %0d, got %0d",
                               $signed(want), $signed(m_tdata[19:0]));
                        fail_count++;
                    end
                    if (m_tdata[bab_pkg::OUT_TDATA_W-1:20] !== '0) begin
                        $error("tdata pad: expected 0, got %h",
                               m_tdata[bab_pkg::OUT_TDATA_W-1:20]);
                        fail_count++;
                    end
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("bearing_angle_between_points verification failed");
        $finish;
    end

    initial begin
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (DIRECTED_ROWS[i]) begin
            send_pair(DIRECTED_ROWS[i].pts, DIRECTED_ROWS[i].pinned, DIRECTED_ROWS[i].want);
        end
        drain();

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    src_idle_pct   = 10;
                    sink_stall_pct = 50;
                end
                1: begin
                    src_idle_pct   = 50;
                    sink_stall_pct = 10;
                end
                default: begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
            endcase
            for (int n = 0; n < N_RANDOM / 3; n++) begin
                send_pair(random_pair(), 1'b0, 20'd0);
            end
            drain();
        end

        repeat (2 * LATENCY) @(negedge aclk);
        if (fail_count == 0 && bearing_q.size() == 0) begin
            $display("bearing_angle_between_points verification clean");
        end else begin
            $display("bearing_angle_between_points verification failed");
        end
        $finish;
    end

endmodule
